// ===== hw/rtl/sce_pkg.sv =====
// shared constants, types and word codes of the sparse column delta encoder
`timescale 1ns / 1ps

package sce_pkg;

	localparam int BUFFER_WORDS = 32;
	localparam int PAYLOAD_BITS = 28;

	localparam int IDX_W  = 60;
	localparam int WORD_W = 32;
	localparam int HDR_W  = WORD_W - PAYLOAD_BITS;
	localparam int BW_W   = 29;
	localparam int OFF_W  = 28;
	localparam int ADDR_W = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
	localparam int CNT_W  = $clog2(BUFFER_WORDS + 1);
	localparam int PAIR_W = PAYLOAD_BITS / 2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BW_W-1:0]   bw_t;
	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [HDR_W-1:0]  hdr_t;

	localparam hdr_t HDR_PAIR    = hdr_t'(9);
	localparam hdr_t HDR_SHORT   = hdr_t'(8);
	localparam hdr_t HDR_LONGROW = hdr_t'(10);
	localparam hdr_t HDR_LONGCOL = hdr_t'(6);

	localparam idx_t MAX14 = idx_t'((1 << PAIR_W) - 1);
	localparam idx_t MAX28 = idx_t'((64'd1 << PAYLOAD_BITS) - 64'd1);

	localparam bw_t BW_MIN   = bw_t'(64);
	localparam bw_t BW_MAX   = bw_t'(268435456);
	localparam bw_t BW_RESET = bw_t'(4194304);

	localparam logic MODE_ROW   = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	localparam logic KIND_PAD  = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b0000_0000_0001,
		ST_NORM      = 12'b0000_0000_0010,
		ST_DECIDE    = 12'b0000_0000_0100,
		ST_SINGLE    = 12'b0000_0000_1000,
		ST_SINGLE_LO = 12'b0000_0001_0000,
		ST_END_CHK   = 12'b0000_0010_0000,
		ST_EMIT_CALC = 12'b0000_0100_0000,
		ST_PAD       = 12'b0000_1000_0000,
		ST_HDR0      = 12'b0001_0000_0000,
		ST_HDR1      = 12'b0010_0000_0000,
		ST_WORDS     = 12'b0100_0000_0000,
		ST_FLUSH     = 12'b1000_0000_0000
	} state_t;

	// control and status of the offset remainder unit
	typedef struct packed {
		logic start;
	} rem_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_sts_t;

endpackage

// ===== hw/rtl/sce_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sce_rem.sv =====
// iterative restoring remainder, one dividend bit per cycle
`timescale 1ns / 1ps

module sce_rem import sce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rem_ctl_t ctl,
	input  off_t     dividend,
	input  bw_t      divisor,
	output rem_sts_t sts,
	output off_t     result
);

	localparam int STEP_W = $clog2(OFF_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	bw_t               rem_q;
	off_t              div_q;
	bw_t               trial;

	assign trial = {rem_q[OFF_W-1:0], div_q[OFF_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(OFF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			div_q <= dividend;
		end else if (busy_q) begin
			rem_q <= (trial >= divisor) ? (trial - divisor) : trial;
			div_q <= {div_q[OFF_W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = rem_q[OFF_W-1:0];

endmodule

// ===== hw/rtl/sparse_column_delta_encoder_unit.sv =====
// top level of the sparse column delta encoder: sequencer, buffer and output register
`timescale 1ns / 1ps

// Sparse column delta encoder. Row indices of one column arrive in ascending
// order, one item each, and are coded into 32-bit words (pairs of 14-bit
// deltas, single 28-bit deltas, or two-word long rows) that are written into a
// 32-entry word buffer in a one-port-write, one-port-read ram. A row item with
// column_end set drains the column: an optional zero-pad run so that the two
// column header words and the column do not cross a block_words boundary, the
// header, then the buffered words. A flush item emits one pad run up to the
// next boundary, or nothing at a boundary. Words beyond the buffer size are
// dropped and the column's results carry overflow. A row item that only pairs
// or parks its row passes through ST_DECIDE, one that codes a single row also
// through ST_SINGLE and ST_END_CHK (and ST_SINGLE_LO for a long row, the
// buffer takes one write a cycle); a column end item then codes any parked row
// and sets up the drain in ST_EMIT_CALC. The drain delivers one result per
// cycle while out_stall is low, fed from the ram through its registered read.
// A write to block_words starts a 28-step remainder pass that folds the block
// offset into the new block size; no item is accepted until the pass is done.
// Buffer writes and drain reads never overlap, so no forwarding is needed. The
// next item is accepted while a finished result still waits in the output register.

module sparse_column_delta_encoder_unit import sce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  bw_t         cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  idx_t        col_index,
	input  idx_t        row,
	input  logic        column_end,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output word_t       word,
	output bw_t         pad_count,
	output logic        last,
	output logic        overflow
);

	// control state
	state_t state_q;
	bw_t    block_words_q;
	logic   norm_req_q;
	logic   pend_valid_q;
	idx_t   pend_row_q;
	idx_t   prev_row_q;
	off_t   block_offset_q;
	off_t   off_raw_q;
	logic   ovf_flag_q;
	cnt_t   word_count_q;
	cnt_t   emit_wc_q;
	cnt_t   rd_idx_q;
	logic   rv_s1;
	logic   out_valid_q;

	// payload registers
	idx_t   row_q;
	idx_t   col_q;
	logic   col_end_q;
	idx_t   sgl_row_q;
	bw_t    pad_q;
	logic   ovf_emit_q;
	logic   last_s1;
	logic   kind_q;
	word_t  word_q;
	bw_t    pad_count_q;
	logic   last_q;
	logic   ovf_q;

	// effective block size, clamped to the legal range
	bw_t bw_eff;
	always_comb begin
		if (block_words_q < BW_MIN) begin
			bw_eff = BW_MIN;
		end else if (block_words_q > BW_MAX) begin
			bw_eff = BW_MAX;
		end else begin
			bw_eff = block_words_q;
		end
	end

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE) || norm_req_q || cfg_we;
	assign in_acc   = in_valid && !in_stall;

	// output register is free when empty or being taken
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// pair test: both deltas nonnegative and below the 14-bit limit
	logic [IDX_W:0] d1_full, d2_full, ds_full;
	logic           pair_ok, short_ok;
	assign d1_full  = {1'b0, pend_row_q} - {1'b0, prev_row_q};
	assign d2_full  = {1'b0, row_q} - {1'b0, pend_row_q};
	assign pair_ok  = !d1_full[IDX_W] && (d1_full[IDX_W-1:0] < MAX14)
	               && !d2_full[IDX_W] && (d2_full[IDX_W-1:0] < MAX14);
	// single row test against the previous row
	assign ds_full  = {1'b0, sgl_row_q} - {1'b0, prev_row_q};
	assign short_ok = !ds_full[IDX_W] && (ds_full[IDX_W-1:0] < MAX28);

	// drain set-up arithmetic
	bw_t  need_sum;
	bw_t  pad_full;
	logic need_pad;
	assign need_sum = bw_t'(block_offset_q) + bw_t'(word_count_q) + bw_t'(2);
	assign pad_full = bw_eff - bw_t'(block_offset_q);
	assign need_pad = need_sum > bw_eff;

	// buffer writes
	logic  push_en;
	word_t push_word;
	logic  room;
	always_comb begin
		push_en   = 1'b0;
		push_word = '0;
		unique case (state_q)
			ST_DECIDE: begin
				if (pend_valid_q && pair_ok) begin
					push_en   = 1'b1;
					push_word = {HDR_PAIR, d1_full[PAIR_W-1:0], d2_full[PAIR_W-1:0]};
				end
			end
			ST_SINGLE: begin
				push_en = 1'b1;
				if (short_ok) begin
					push_word = {HDR_SHORT, ds_full[PAYLOAD_BITS-1:0]};
				end else begin
					push_word = {HDR_LONGROW, sgl_row_q[IDX_W-1:WORD_W]};
				end
			end
			ST_SINGLE_LO: begin
				push_en   = 1'b1;
				push_word = sgl_row_q[WORD_W-1:0];
			end
			default: begin
				push_en   = 1'b0;
				push_word = '0;
			end
		endcase
	end
	assign room = word_count_q < cnt_t'(BUFFER_WORDS);

	// drain read pipeline: ram output register is stage 1
	logic  rd_issue;
	logic  move_s1;
	logic  rd_phase;
	word_t ram_rdata;
	assign rd_phase = (state_q == ST_HDR0) || (state_q == ST_HDR1) || (state_q == ST_WORDS);
	assign move_s1  = (state_q == ST_WORDS) && rv_s1 && out_free;
	assign rd_issue = rd_phase && (rd_idx_q < emit_wc_q) && (!rv_s1 || move_s1);

	sce_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BUFFER_WORDS)
	) u_buf (
		.clk   (clk),
		.we    (push_en && room),
		.waddr (word_count_q[ADDR_W-1:0]),
		.wdata (push_word),
		.re    (rd_issue),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// offset fold after a block size change, always from the unfolded offset
	rem_ctl_t rem_ctl;
	rem_sts_t rem_sts;
	off_t     rem_result;
	assign rem_ctl.start = (state_q == ST_IDLE) && norm_req_q;

	sce_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rem_ctl),
		.dividend (off_raw_q),
		.divisor  (bw_eff),
		.sts      (rem_sts),
		.result   (rem_result)
	);

	// output register load
	logic  out_load;
	logic  ld_kind;
	word_t ld_word;
	bw_t   ld_pad;
	logic  ld_last;
	logic  ld_ovf;
	always_comb begin
		out_load = 1'b0;
		ld_kind  = KIND_WORD;
		ld_word  = '0;
		ld_pad   = '0;
		ld_last  = 1'b0;
		ld_ovf   = ovf_emit_q;
		unique case (state_q)
			ST_FLUSH: begin
				out_load = out_free && (block_offset_q != '0);
				ld_kind  = KIND_PAD;
				ld_pad   = pad_full;
				ld_last  = 1'b1;
				ld_ovf   = 1'b0;
			end
			ST_PAD: begin
				out_load = out_free;
				ld_kind  = KIND_PAD;
				ld_pad   = pad_q;
			end
			ST_HDR0: begin
				out_load = out_free;
				ld_word  = {HDR_LONGCOL, col_q[IDX_W-1:WORD_W]};
			end
			ST_HDR1: begin
				out_load = out_free;
				ld_word  = col_q[WORD_W-1:0];
				ld_last  = (emit_wc_q == '0);
			end
			ST_WORDS: begin
				out_load = move_s1;
				ld_word  = ram_rdata;
				ld_last  = last_s1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			block_words_q  <= BW_RESET;
			norm_req_q     <= 1'b0;
			pend_valid_q   <= 1'b0;
			pend_row_q     <= '0;
			prev_row_q     <= '0;
			block_offset_q <= '0;
			off_raw_q      <= '0;
			ovf_flag_q     <= 1'b0;
			word_count_q   <= '0;
			emit_wc_q      <= '0;
			rd_idx_q       <= '0;
			rv_s1          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_words_q <= cfg_wdata;
			end

			if (push_en) begin
				if (room) begin
					word_count_q <= word_count_q + cnt_t'(1);
				end else begin
					ovf_flag_q <= 1'b1;
				end
			end

			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + cnt_t'(1);
				rv_s1    <= 1'b1;
			end else if (move_s1) begin
				rv_s1 <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (norm_req_q) begin
						state_q <= ST_NORM;
					end else if (in_acc) begin
						state_q <= (mode == MODE_FLUSH) ? ST_FLUSH : ST_DECIDE;
					end
				end
				ST_NORM: begin
					if (rem_sts.done) begin
						block_offset_q <= rem_result;
						state_q        <= ST_IDLE;
					end
				end
				ST_DECIDE: begin
					if (pend_valid_q && !pair_ok) begin
						pend_row_q <= row_q;
						state_q    <= ST_SINGLE;
					end else begin
						if (pend_valid_q) begin
							prev_row_q   <= row_q;
							pend_valid_q <= 1'b0;
						end else begin
							pend_row_q   <= row_q;
							pend_valid_q <= 1'b1;
						end
						state_q <= col_end_q ? ST_END_CHK : ST_IDLE;
					end
				end
				ST_SINGLE: begin
					if (short_ok) begin
						prev_row_q <= sgl_row_q;
						state_q    <= ST_END_CHK;
					end else begin
						state_q <= ST_SINGLE_LO;
					end
				end
				ST_SINGLE_LO: begin
					prev_row_q <= sgl_row_q;
					state_q    <= ST_END_CHK;
				end
				ST_END_CHK: begin
					if (!col_end_q) begin
						state_q <= ST_IDLE;
					end else if (pend_valid_q) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_SINGLE;
					end else begin
						state_q <= ST_EMIT_CALC;
					end
				end
				ST_EMIT_CALC: begin
					if (need_pad) begin
						block_offset_q <= off_t'(bw_t'(word_count_q) + bw_t'(2));
						off_raw_q      <= off_t'(bw_t'(word_count_q) + bw_t'(2));
						state_q        <= ST_PAD;
					end else begin
						block_offset_q <= (need_sum == bw_eff) ? '0 : need_sum[OFF_W-1:0];
						off_raw_q      <= (need_sum == bw_eff) ? '0 : need_sum[OFF_W-1:0];
						state_q        <= ST_HDR0;
					end
					emit_wc_q    <= word_count_q;
					word_count_q <= '0;
					ovf_flag_q   <= 1'b0;
					prev_row_q   <= '0;
					pend_row_q   <= '0;
					pend_valid_q <= 1'b0;
					rd_idx_q     <= '0;
				end
				ST_PAD: begin
					if (out_free) begin
						state_q <= ST_HDR0;
					end
				end
				ST_HDR0: begin
					if (out_free) begin
						state_q <= ST_HDR1;
					end
				end
				ST_HDR1: begin
					if (out_free) begin
						state_q <= (emit_wc_q == '0) ? ST_IDLE : ST_WORDS;
					end
				end
				ST_WORDS: begin
					if (move_s1 && last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// a flush always restarts the offset, padded or not
					if (block_offset_q == '0) begin
						off_raw_q <= '0;
						state_q   <= ST_IDLE;
					end else if (out_free) begin
						block_offset_q <= '0;
						off_raw_q      <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// a size change folds the offset before the next item
			if (cfg_we) begin
				norm_req_q <= 1'b1;
			end else if (rem_ctl.start) begin
				norm_req_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q     <= row;
			col_q     <= col_index;
			col_end_q <= column_end;
		end
		if ((state_q == ST_DECIDE) || (state_q == ST_END_CHK)) begin
			sgl_row_q <= pend_row_q;
		end
		if (state_q == ST_EMIT_CALC) begin
			pad_q      <= pad_full;
			ovf_emit_q <= ovf_flag_q;
		end
		if (rd_issue) begin
			last_s1 <= (rd_idx_q + cnt_t'(1)) == emit_wc_q;
		end
		if (out_load) begin
			kind_q      <= ld_kind;
			word_q      <= ld_word;
			pad_count_q <= ld_pad;
			last_q      <= ld_last;
			ovf_q       <= ld_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign word      = word_q;
	assign pad_count = pad_count_q;
	assign last      = last_q;
	assign overflow  = ovf_q;

	// buffer fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= cnt_t'(BUFFER_WORDS))
		else $error("word count beyond buffer depth");

	// offset stays inside the block once folded
	a_offset_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !norm_req_q) |-> (bw_t'(block_offset_q) < bw_eff))
		else $error("block offset not below block size");

	// drain reads and coding writes never share a cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> !push_en)
		else $error("buffer read during coding write");

	// read stage holds data only while draining
	a_read_stage_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_HDR0 || state_q == ST_HDR1 || state_q == ST_WORDS))
		else $error("read stage busy outside drain");

endmodule

// ===== verif/tb_sparse_column_delta_encoder_unit.sv =====
// testbench of the sparse column delta encoder: directed table, random columns, scoreboard
`timescale 1ns / 1ps

module tb_sparse_column_delta_encoder_unit;
	import sce_pkg::*;

	// one input item as the block sees it
	typedef struct packed {
		logic mode;
		idx_t col_index;
		idx_t row;
		logic column_end;
	} enc_item_t;

	// one result item
	typedef struct packed {
		logic  kind;
		word_t word;
		bw_t   pad_count;
		logic  last;
		logic  ovf;
	} enc_result_t;

	// a row of the directed table; typed rows carry their results in TYPED_RESULTS
	typedef struct packed {
		enc_item_t  it;
		logic       typed;
		logic [2:0] n_typed;
	} dir_row_t;

	localparam int N_DIRECTED      = 17;
	localparam int N_TYPED         = 8;
	localparam int N_PHASES        = 8;
	localparam int RANDOM_PHASE    = 6;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int QUIET_CYCLES    = 16;
	localparam int END_CYCLES      = 40;
	localparam int WATCHDOG_LIMIT  = 2000;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// flush straight after reset: already on a boundary, no result
		'{'{MODE_FLUSH, 60'd0, 60'd0, 1'b0}, 1'b1, 3'd0},
		// one-row column at row zero, column zero
		'{'{MODE_ROW, 60'd0, 60'd0, 1'b1}, 1'b1, 3'd3},
		// all-ones column and row: long column header and a long row
		'{'{MODE_ROW, 60'hFFF_FFFF_FFFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, 3'd4},
		// flush at offset 7 pads the rest of the reset-size block
		'{'{MODE_FLUSH, 60'd0, 60'd0, 1'b0}, 1'b1, 3'd1},
		// pair with the second delta just under the pair limit, then a lone short
		'{'{MODE_ROW, 60'h0AB_CDEF_0123_4567, 60'd100, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'h0AB_CDEF_0123_4567, 60'd16482, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'h0AB_CDEF_0123_4567, 60'd32865, 1'b1}, 1'b0, 3'd0},
		// deltas right at the pair limit refuse to pair
		'{'{MODE_ROW, 60'h555_5555_5555_5555, 60'd50, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'h555_5555_5555_5555, 60'd16433, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'h555_5555_5555_5555, 60'd16438, 1'b1}, 1'b0, 3'd0},
		// largest short delta, then a delta at the short limit goes long
		'{'{MODE_ROW, 60'hAAA_AAAA_AAAA_AAAA, 60'd268435454, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'hAAA_AAAA_AAAA_AAAA, 60'd536870909, 1'b1}, 1'b0, 3'd0},
		// descending row is coded as a long row
		'{'{MODE_ROW, 60'd1, 60'd1000, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'd1, 60'd500, 1'b1}, 1'b0, 3'd0},
		// flush in the middle of a column, junk in the ignored fields
		'{'{MODE_ROW, 60'd2, 60'd7, 1'b0}, 1'b0, 3'd0},
		'{'{MODE_FLUSH, 60'hFFF_FFFF_FFFF_FFFF, 60'h123, 1'b1}, 1'b0, 3'd0},
		'{'{MODE_ROW, 60'hFFF_FFFF_FFFF_FFFF, 60'd9, 1'b1}, 1'b0, 3'd0}
	};

	localparam enc_result_t TYPED_RESULTS [N_TYPED] = '{
		'{KIND_WORD, {HDR_LONGCOL, 28'h000_0000}, 29'd0, 1'b0, 1'b0},
		'{KIND_WORD, 32'h0000_0000, 29'd0, 1'b0, 1'b0},
		'{KIND_WORD, {HDR_SHORT, 28'h000_0000}, 29'd0, 1'b1, 1'b0},
		'{KIND_WORD, {HDR_LONGCOL, 28'hFFF_FFFF}, 29'd0, 1'b0, 1'b0},
		'{KIND_WORD, 32'hFFFF_FFFF, 29'd0, 1'b0, 1'b0},
		'{KIND_WORD, {HDR_LONGROW, 28'hFFF_FFFF}, 29'd0, 1'b0, 1'b0},
		'{KIND_WORD, 32'hFFFF_FFFF, 29'd0, 1'b1, 1'b0},
		'{KIND_PAD, 32'h0000_0000, BW_RESET - bw_t'(7), 1'b1, 1'b0}
	};

	// block settings per phase; the random phase draws its own size
	localparam bw_t CFG_SETTINGS [N_PHASES] = '{
		bw_t'(64), bw_t'(0), bw_t'(29'h1FFF_FFFF), bw_t'(100),
		BW_MAX, bw_t'(63), bw_t'(0), BW_RESET
	};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	bw_t   cfg_wdata = '0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	logic  mode = MODE_ROW;
	idx_t  col_index = '0;
	idx_t  row = '0;
	logic  column_end = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	logic  kind;
	word_t word;
	bw_t   pad_count;
	logic  last;
	logic  overflow;

	// expected results, oldest first
	enc_result_t exp_results[$];
	int errors = 0;
	int items_sent = 0;
	int typed_pos = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int unsigned cyc = 0;
	logic [1:0] stall_mode = 2'd0;

	// encoder model state
	bw_t   blk_words = BW_RESET;
	word_t coded_buf [BUFFER_WORDS];
	cnt_t  wcount = '0;
	logic  pend_v = 1'b0;
	idx_t  pend_row = '0;
	idx_t  prev_row = '0;
	off_t  blk_off = '0;
	logic  ovf_flag = 1'b0;

	sparse_column_delta_encoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.col_index  (col_index),
		.row        (row),
		.column_end (column_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.word       (word),
		.pad_count  (pad_count),
		.last       (last),
		.overflow   (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block size as the block uses it: clamped to its legal range
	function automatic bw_t eff_block_size();
		if (blk_words < BW_MIN) return BW_MIN;
		if (blk_words > BW_MAX) return BW_MAX;
		return blk_words;
	endfunction

	// buffer one coded word, or drop it and flag overflow when full
	task automatic buffer_word(input word_t w);
		if (wcount < BUFFER_WORDS) begin
			coded_buf[wcount] = w;
			wcount++;
		end else begin
			ovf_flag = 1'b1;
		end
	endtask

	// a row on its own: short delta if it fits, else long row with the absolute index
	task automatic code_row(input idx_t r);
		idx_t d;
		d = r - prev_row;
		if (r >= prev_row && d < MAX28) begin
			buffer_word({HDR_SHORT, d[PAYLOAD_BITS-1:0]});
		end else begin
			buffer_word({HDR_LONGROW, r[IDX_W-1:32]});
			buffer_word(r[31:0]);
		end
		prev_row = r;
	endtask

	// works out the results that one accepted item causes and advances the model
	task automatic encode_item(input enc_item_t it, ref enc_result_t res[$]);
		bw_t bw;
		bw_t off;
		bw_t pad;
		idx_t d1;
		idx_t d2;
		longint unsigned need;
		logic ovf;
		bw = eff_block_size();
		off = bw_t'(blk_off % bw);
		pad = '0;
		if (it.mode == MODE_FLUSH) begin
			// a flush on the boundary gives nothing
			if (off != '0) res.push_back('{KIND_PAD, '0, bw - off, 1'b1, 1'b0});
			blk_off = '0;
			return;
		end
		if (pend_v) begin
			d1 = pend_row - prev_row;
			d2 = it.row - pend_row;
			if (pend_row >= prev_row && d1 < MAX14 && it.row >= pend_row && d2 < MAX14) begin
				buffer_word({HDR_PAIR, d1[PAIR_W-1:0], d2[PAIR_W-1:0]});
				prev_row = it.row;
				pend_v = 1'b0;
			end else begin
				code_row(pend_row);
				pend_row = it.row;
			end
		end else begin
			pend_row = it.row;
			pend_v = 1'b1;
		end
		if (!it.column_end) return;
		if (pend_v) begin
			code_row(pend_row);
			pend_v = 1'b0;
		end
		// pad when header plus words would cross the block boundary
		need = longint'(off) + longint'(wcount) + 2;
		if (need > longint'(bw)) pad = bw - off;
		ovf = ovf_flag;
		if (pad != '0) res.push_back('{KIND_PAD, '0, pad, 1'b0, ovf});
		res.push_back('{KIND_WORD, {HDR_LONGCOL, it.col_index[IDX_W-1:32]}, '0, 1'b0, ovf});
		res.push_back('{KIND_WORD, it.col_index[31:0], '0, wcount == '0, ovf});
		for (int i = 0; i < int'(wcount); i++)
			res.push_back('{KIND_WORD, coded_buf[i], '0, i + 1 == int'(wcount), ovf});
		blk_off = off_t'((longint'(off) + longint'(pad) + longint'(wcount) + 2) % longint'(bw));
		wcount = '0;
		prev_row = '0;
		pend_row = '0;
		pend_v = 1'b0;
		ovf_flag = 1'b0;
	endtask

	function automatic idx_t rand_idx();
		return idx_t'({$urandom, $urandom});
	endfunction

	// flush item with random junk in the fields it ignores
	function automatic enc_item_t random_flush();
		return '{MODE_FLUSH, rand_idx(), rand_idx(), 1'($urandom_range(0, 1))};
	endfunction

	// next row of a column: mostly pairable steps, some at the pair and short limits,
	// some long rows and a few going backwards; wide columns are mostly long rows
	function automatic idx_t next_row(input idx_t r, input logic wide);
		int unsigned p;
		if (wide) p = ($urandom_range(0, 5) == 0) ? 0 : 8;
		else p = $urandom_range(0, 9);
		case (p)
			0, 1, 2, 3, 4: return r + idx_t'($urandom_range(0, 16382));
			5: return r + idx_t'($urandom_range(16382, 16384));
			6: return r + idx_t'($urandom_range(16384, 268435455));
			7: return r + idx_t'($urandom_range(268435453, 268435457));
			8: return rand_idx();
			default: return r - idx_t'($urandom_range(1, 5000));
		endcase
	endfunction

	// drive one item at this edge, hold it until taken, then book its results;
	// between bursts the sender drops valid for a random gap
	task automatic send_item(input enc_item_t it, input logic use_typed, input int n_typed);
		enc_result_t predicted[$];
		int gap;
		mode <= it.mode;
		col_index <= it.col_index;
		row <= it.row;
		column_end <= it.column_end;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		encode_item(it, predicted);
		if (use_typed) begin
			for (int k = 0; k < n_typed; k++) begin
				exp_results.push_back(TYPED_RESULTS[typed_pos]);
				typed_pos++;
			end
		end else begin
			foreach (predicted[k]) exp_results.push_back(predicted[k]);
		end
		items_sent++;
		if (burst_left == 0) begin
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// stop sending and wait until every booked result has come, then let the block settle
	task automatic drain_wait(input int extra);
		in_valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// result checker, receiver stall pattern and idle count for the watchdog
	always @(posedge clk) begin
		enc_result_t got;
		enc_result_t want;
		cyc <= cyc + 1;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, word, pad_count, last, overflow};
			if (exp_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got kind %h word %h pad %0d last %h ovf %h",
					$time, got.kind, got.word, got.pad_count, got.last, got.ovf);
			end else begin
				want = exp_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("word", want.word, got.word);
				check_field("pad_count", 32'(want.pad_count), 32'(got.pad_count));
				check_field("last", 32'(want.last), 32'(got.last));
				check_field("overflow", 32'(want.ovf), 32'(got.ovf));
			end
		end
		// receiver style, redrawn periodically: none, random, short periodic, long holds
		if (cyc[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 2) == 0);
			2'd2: out_stall <= ((cyc % 5) < 2);
			default: out_stall <= ((cyc % 32) < 20);
		endcase
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	// watchdog: too long with no item moving on either side
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb_sparse_column_delta_encoder_unit: errors");
		$finish;
	end

	initial begin
		enc_item_t it;
		idx_t r;
		int len;
		int pick;
		int phase_end;
		bw_t cfg_val;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset block size
		for (int n = 0; n < N_DIRECTED; n++)
			send_item(DIRECTED[n].it, DIRECTED[n].typed, int'(DIRECTED[n].n_typed));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// block idle: all results in and the last item settled
			drain_wait(QUIET_CYCLES);
			cfg_val = CFG_SETTINGS[ph];
			if (ph == RANDOM_PHASE) cfg_val = bw_t'($urandom_range(64, 400));
			cfg_wdata <= cfg_val;
			cfg_we <= 1'b1;
			@(posedge clk);
			cfg_we <= 1'b0;
			blk_words = cfg_val;
			@(posedge clk);

			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_item(random_flush(), 1'b0, 0);
				end else if (pick == 1) begin
					// noise: anything the fields allow
					it = '{1'($urandom_range(0, 1)), rand_idx(), rand_idx(), 1'($urandom_range(0, 1))};
					send_item(it, 1'b0, 0);
				end else begin
					// a well-formed column; pick 2 is a long one that can overrun the buffer
					len = (pick == 2) ? $urandom_range(17, 22) : $urandom_range(1, 8);
					it.mode = MODE_ROW;
					it.col_index = rand_idx();
					r = '0;
					for (int j = 0; j < len; j++) begin
						r = next_row(r, pick == 2);
						it.row = r;
						it.column_end = (j == len - 1);
						send_item(it, 1'b0, 0);
						if ($urandom_range(0, 39) == 0) send_item(random_flush(), 1'b0, 0);
					end
				end
			end
		end

		drain_wait(END_CYCLES);
		if (errors == 0) begin
			$display("tb_sparse_column_delta_encoder_unit: clean");
		end else begin
			$display("tb_sparse_column_delta_encoder_unit: errors");
		end
		$finish;
	end

endmodule
